// ----- design/ffsa_pkg.sv -----
package ffsa_pkg;

    // Build defaults
    localparam int SLOTS_DEF    = 128;
    localparam int AGE_BITS_DEF = 16;

    // Fixed field widths
    localparam int CFG_W    = 8;
    localparam int SIZE_W   = 8;
    localparam int AGE_IN_W = 16;
    localparam int START_W  = 7;
    localparam int FREED_W  = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_ALLOC_FILL,
        ST_EVICT_MIN,
        ST_EVICT_FREE,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        SCAN_ALLOC,
        SCAN_MIN,
        SCAN_FREE
    } t_scan;

    typedef struct packed {
        logic  req_ready;
        logic  load;
        logic  clear;
        logic  scan;
        t_scan mode;
        logic  fill;
        logic  rewind;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic in_action;
        logic clear_last;
        logic scan_done;
        logic found;
        logic any;
        logic fill_last;
        logic out_free;
    } t_status;

endpackage

// ----- design/ffsa_ifs.sv -----
interface ffsa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [ffsa_pkg::SIZE_W-1:0]   size;
    logic [ffsa_pkg::AGE_IN_W-1:0] age_stamp;

    modport source (output valid, output action, output size, output age_stamp,
                    input ready);
    modport sink (input valid, input action, input size, input age_stamp,
                  output ready);
endinterface

interface ffsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [ffsa_pkg::START_W-1:0]  start_slot;
    logic [ffsa_pkg::AGE_IN_W-1:0] evicted_age;
    logic [ffsa_pkg::FREED_W-1:0]  freed_count;

    modport source (output valid, output granted, output start_slot,
                    output evicted_age, output freed_count, input ready);
    modport sink (input valid, input granted, input start_slot,
                  input evicted_age, input freed_count, output ready);
endinterface

interface ffsa_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ffsa_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/ffsa_ctrl.sv -----
module ffsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  ffsa_pkg::t_status i_status,
    output ffsa_pkg::t_cmd    o_cmd
);

    ffsa_pkg::t_state r_state;
    ffsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffsa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffsa_pkg::ST_CLEAR: begin
                if (i_status.clear_last) n_state = ffsa_pkg::ST_IDLE;
            end
            ffsa_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = i_status.in_action ? ffsa_pkg::ST_EVICT_MIN
                                                 : ffsa_pkg::ST_ALLOC_SCAN;
                end
            end
            ffsa_pkg::ST_ALLOC_SCAN: begin
                if (i_status.found) n_state = ffsa_pkg::ST_ALLOC_FILL;
                else if (i_status.scan_done) n_state = ffsa_pkg::ST_FINISH;
            end
            ffsa_pkg::ST_ALLOC_FILL: begin
                if (i_status.fill_last) n_state = ffsa_pkg::ST_FINISH;
            end
            ffsa_pkg::ST_EVICT_MIN: begin
                if (i_status.scan_done) begin
                    n_state = i_status.any ? ffsa_pkg::ST_EVICT_FREE
                                           : ffsa_pkg::ST_FINISH;
                end
            end
            ffsa_pkg::ST_EVICT_FREE: begin
                if (i_status.scan_done) n_state = ffsa_pkg::ST_FINISH;
            end
            ffsa_pkg::ST_FINISH: begin
                if (i_status.out_free) n_state = ffsa_pkg::ST_IDLE;
            end
            default: n_state = ffsa_pkg::ST_CLEAR;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.mode = ffsa_pkg::SCAN_ALLOC;
        unique case (r_state)
            ffsa_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ffsa_pkg::ST_IDLE: begin
                o_cmd.req_ready = 1'b1;
                o_cmd.load      = i_req_valid;
            end
            ffsa_pkg::ST_ALLOC_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.mode = ffsa_pkg::SCAN_ALLOC;
            end
            ffsa_pkg::ST_ALLOC_FILL: begin
                o_cmd.fill = 1'b1;
            end
            ffsa_pkg::ST_EVICT_MIN: begin
                o_cmd.scan   = 1'b1;
                o_cmd.mode   = ffsa_pkg::SCAN_MIN;
                o_cmd.rewind = i_status.scan_done;
            end
            ffsa_pkg::ST_EVICT_FREE: begin
                o_cmd.scan = 1'b1;
                o_cmd.mode = ffsa_pkg::SCAN_FREE;
            end
            ffsa_pkg::ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: o_cmd.clear = 1'b0;
        endcase
    end

endmodule

// ----- design/ffsa_dp.sv -----
module ffsa_dp #(
    parameter int SLOTS    = ffsa_pkg::SLOTS_DEF,
    parameter int AGE_BITS = ffsa_pkg::AGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffsa_pkg::t_cmd                i_cmd,
    output ffsa_pkg::t_status             o_status,
    input  logic                          i_req_action,
    input  logic [ffsa_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffsa_pkg::AGE_IN_W-1:0] i_req_age,
    input  logic                          i_cfg_valid,
    input  logic [ffsa_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic                          o_rsp_granted,
    output logic [ffsa_pkg::START_W-1:0]  o_rsp_start,
    output logic [ffsa_pkg::AGE_IN_W-1:0] o_rsp_age,
    output logic [ffsa_pkg::FREED_W-1:0]  o_rsp_freed
);

    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CMP_W     = (CNT_W > ffsa_pkg::CFG_W) ? CNT_W : ffsa_pkg::CFG_W;
    localparam int WORD_W    = AGE_BITS + 1;
    localparam int START_W   = ffsa_pkg::START_W;
    localparam int AGE_OUT_W = ffsa_pkg::AGE_IN_W;
    localparam int FREED_W   = ffsa_pkg::FREED_W;

    // Slot table: occupied flag on top of the age
    logic [WORD_W-1:0] r_mem [SLOTS];
    logic [WORD_W-1:0] r_rd_data;

    logic [ffsa_pkg::CFG_W-1:0]  r_cfg;
    logic                        r_action;
    logic [ffsa_pkg::SIZE_W-1:0] r_size;
    logic [AGE_BITS-1:0]         r_age;
    logic [CNT_W-1:0]            r_n;
    logic [CNT_W-1:0]            r_rd_cnt;
    logic                        r_rd_vld;
    logic [IDX_W-1:0]            r_rd_idx;
    logic [IDX_W-1:0]            r_clr;
    logic [CNT_W-1:0]            r_run;
    logic                        r_found;
    logic [IDX_W-1:0]            r_start;
    logic [IDX_W-1:0]            r_fill_idx;
    logic [CNT_W-1:0]            r_fill_left;
    logic                        r_any;
    logic [AGE_BITS-1:0]         r_least;
    logic [CNT_W-1:0]            r_freed;
    logic                        r_out_valid;
    logic                        r_out_granted;
    logic [START_W-1:0]          r_out_start;
    logic [AGE_OUT_W-1:0]        r_out_age;
    logic [FREED_W-1:0]          r_out_freed;

    logic [CNT_W-1:0]    w_n;
    logic                w_occ;
    logic [AGE_BITS-1:0] w_age;
    logic                w_proc;
    logic                w_issue;
    logic [CNT_W-1:0]    w_run_inc;
    logic                w_hit;
    logic                w_lower;
    logic                w_free_hit;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    logic [WORD_W-1:0]   w_wr_data;
    logic [IDX_W-1:0]    w_rd_addr;

    assign w_n = (CMP_W'(r_cfg) < CMP_W'(SLOTS)) ? CNT_W'(r_cfg) : CNT_W'(SLOTS);

    assign w_occ     = r_rd_data[AGE_BITS];
    assign w_age     = r_rd_data[AGE_BITS-1:0];
    assign w_proc    = i_cmd.scan && r_rd_vld;
    assign w_issue   = i_cmd.scan && !i_cmd.rewind && (r_rd_cnt != r_n)
                       && !(i_cmd.mode == ffsa_pkg::SCAN_ALLOC && r_found);
    assign w_run_inc = r_run + CNT_W'(1);
    assign w_hit     = w_proc && (i_cmd.mode == ffsa_pkg::SCAN_ALLOC) && !r_found
                       && !w_occ && (CMP_W'(w_run_inc) == CMP_W'(r_size));
    assign w_lower   = w_occ && (!r_any || (w_age < r_least));
    assign w_free_hit = w_proc && (i_cmd.mode == ffsa_pkg::SCAN_FREE)
                        && w_occ && (w_age == r_least);
    assign w_rd_addr = r_rd_cnt[IDX_W-1:0];

    // Write port select
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr;
        w_wr_data = '0;
        priority if (i_cmd.clear) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.fill) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_fill_idx;
            w_wr_data = {1'b1, r_age};
        end else if (w_free_hit) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= ffsa_pkg::CFG_RESET;
            r_clr       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            if (i_cmd.clear) r_clr <= r_clr + IDX_W'(1);
            if (i_cmd.load || i_cmd.rewind) r_rd_vld <= 1'b0;
            else r_rd_vld <= w_issue;
            if (i_cmd.finish) r_out_valid <= 1'b1;
            else if (i_rsp_ready) r_out_valid <= 1'b0;
        end
    end

    // Scan datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_req_action;
            r_size   <= i_req_size;
            r_age    <= AGE_BITS'(i_req_age);
            r_n      <= w_n;
            r_rd_cnt <= '0;
            r_run    <= '0;
            r_found  <= 1'b0;
            r_any    <= 1'b0;
            r_least  <= '0;
            r_freed  <= '0;
        end else begin
            if (i_cmd.rewind) r_rd_cnt <= '0;
            else if (w_issue) r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            if (w_issue) r_rd_idx <= w_rd_addr;

            if (w_proc && i_cmd.mode == ffsa_pkg::SCAN_ALLOC && !r_found) begin
                r_run <= w_occ ? '0 : w_run_inc;
            end
            if (w_hit) begin
                r_found     <= 1'b1;
                r_start     <= r_rd_idx + IDX_W'(1) - IDX_W'(r_size);
                r_fill_idx  <= r_rd_idx + IDX_W'(1) - IDX_W'(r_size);
                r_fill_left <= CNT_W'(r_size);
            end
            if (i_cmd.fill) begin
                r_fill_idx  <= r_fill_idx + IDX_W'(1);
                r_fill_left <= r_fill_left - CNT_W'(1);
            end

            if (w_proc && i_cmd.mode == ffsa_pkg::SCAN_MIN && w_lower) begin
                r_least <= w_age;
                r_any   <= 1'b1;
            end
            if (w_free_hit) r_freed <= r_freed + CNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_granted <= r_action ? r_any : r_found;
            r_out_start   <= (!r_action && r_found) ? START_W'(r_start) : '0;
            r_out_age     <= (r_action && r_any) ? AGE_OUT_W'(r_least) : '0;
            r_out_freed   <= r_action ? FREED_W'(r_freed) : '0;
        end
    end

    assign o_status.in_action  = i_req_action;
    assign o_status.clear_last = (r_clr == IDX_W'(SLOTS - 1));
    assign o_status.scan_done  = (r_rd_cnt == r_n) && !r_rd_vld;
    assign o_status.found      = r_found;
    assign o_status.any        = r_any;
    assign o_status.fill_last  = (r_fill_left == CNT_W'(1));
    assign o_status.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid   = r_out_valid;
    assign o_rsp_granted = r_out_granted;
    assign o_rsp_start   = r_out_start;
    assign o_rsp_age     = r_out_age;
    assign o_rsp_freed   = r_out_freed;

endmodule

// ----- design/first_fit_slot_allocator.sv -----
// First-fit slot allocator. A table of SLOTS slots, each free or occupied with
// an age, sits in one single-port-write, single-port-read memory. An allocate
// item (action 0) claims the lowest run of `size` free slots among the first
// min(slots_in_use, SLOTS) slots and stamps them with age_stamp; an evict item
// (action 1) frees every occupied slot holding the smallest age. Each item
// yields exactly one result. An allocate item scans the managed slots until
// a run fits (or all are scanned) and then writes the run; an evict item makes
// one pass for the minimum and, if any slot is occupied, one to free, both
// paced by the single memory read port at one slot per cycle. One item is in
// flight at a time; the next one is taken while the previous result still
// waits in the output register. After reset the block runs a clearing pass
// over all SLOTS slots before taking items; configuration writes are always
// taken and must only happen while idle.
module first_fit_slot_allocator #(
    parameter int SLOTS    = ffsa_pkg::SLOTS_DEF,
    parameter int AGE_BITS = ffsa_pkg::AGE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ffsa_req_if.sink     i_req,
    ffsa_rsp_if.source   o_rsp,
    ffsa_cfg_if.sink     i_cfg
);

    ffsa_pkg::t_cmd    w_cmd;
    ffsa_pkg::t_status w_status;

    // Config register is a plain flop, always ready
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_cmd.req_ready;

    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ffsa_dp #(
        .SLOTS    (SLOTS),
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_req_action  (i_req.action),
        .i_req_size    (i_req.size),
        .i_req_age     (i_req.age_stamp),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_rsp_granted (o_rsp.granted),
        .o_rsp_start   (o_rsp.start_slot),
        .o_rsp_age     (o_rsp.evicted_age),
        .o_rsp_freed   (o_rsp.freed_count)
    );

`ifndef ASSERT_OFF
    // One item at a time: after an accept the block is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while an item is in flight");

    // A refused item carries all-zero result fields
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.granted |->
            o_rsp.start_slot == 0 && o_rsp.evicted_age == 0 && o_rsp.freed_count == 0)
        else $error("refused item with nonzero fields");

    // Freed slots only come from a granted evict, which reports no start slot
    a_freed_is_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.freed_count != 0 |-> o_rsp.granted && o_rsp.start_slot == 0)
        else $error("freed count on a non-evict result");
`endif

endmodule
